FILE: hdl/assert_macros.svh
// Assertion macros for the file that checks its own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Whenever the antecedent holds, the consequent must hold in the same cycle.
`define SMRH_ASSERT_IMP(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("implication check failed");

// The expression must never be true outside reset.
`define SMRH_ASSERT_NEVER(name, clk, rstn, expr) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) !(expr)) \
        else $error("forbidden condition seen");

`endif

FILE: hdl/smrh_pkg.sv
// Shared widths, codes and control types of the station memory read handshake.
package smrh_pkg;

    localparam int MAX_READ_BYTES = 15;
    localparam int ADDR_NIBBLES   = 4;

    localparam int MODE_W    = 2;
    localparam int ADDR_W    = 16;
    localparam int CNT_W     = 4;
    localparam int BYTE_W    = 8;
    localparam int WAIT_W    = 5;
    localparam int KIND_W    = 2;
    localparam int STAT_W    = 3;
    localparam int CFG_IDX_W = 2;
    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 16;

    localparam logic [MODE_W-1:0] MODE_START = 2'd0;
    localparam logic [MODE_W-1:0] MODE_RX    = 2'd1;
    localparam logic [MODE_W-1:0] MODE_TICK  = 2'd2;

    localparam logic [KIND_W-1:0] KIND_TX     = 2'd0;
    localparam logic [KIND_W-1:0] KIND_DATA   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_STATUS = 2'd2;

    localparam logic [STAT_W-1:0] STAT_OK        = 3'd0;
    localparam logic [STAT_W-1:0] STAT_SYNC_FAIL = 3'd1;
    localparam logic [STAT_W-1:0] STAT_ECHO_ERR  = 3'd2;
    localparam logic [STAT_W-1:0] STAT_COUNT_ERR = 3'd3;
    localparam logic [STAT_W-1:0] STAT_TIMEOUT   = 3'd4;
    localparam logic [STAT_W-1:0] STAT_CSUM_ERR  = 3'd5;

    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_RETRY = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT    = 2'd1;

    localparam logic [WAIT_W-1:0] RETRY_RESET   = 5'd20;
    localparam logic [WAIT_W-1:0] TIMEOUT_RESET = 5'd19;
    localparam logic [WAIT_W-1:0] WAIT_MAX      = 5'd31;

    localparam logic [BYTE_W-1:0] TX_SYNC       = 8'h06;
    localparam logic [BYTE_W-1:0] RX_SYNC_ACK   = 8'h02;
    localparam logic [BYTE_W-1:0] TX_ADDR_BASE  = 8'h82;
    localparam logic [BYTE_W-1:0] TX_COUNT_BASE = 8'hC2;

    typedef enum logic [2:0] {
        WAIT_KEEP, WAIT_CLEAR, WAIT_ONE, WAIT_INC, WAIT_INC_SAT
    } wait_op_t;

    typedef enum logic [1:0] {
        STEP_KEEP, STEP_CLEAR, STEP_INC
    } step_op_t;

    typedef enum logic [2:0] {
        OUT_SYNC, OUT_NIB_FIRST, OUT_NIB_NEXT, OUT_COUNT, OUT_STATUS, OUT_DATA
    } out_sel_t;

    typedef struct packed {
        logic              in_load;
        logic              start;
        wait_op_t          wait_op;
        step_op_t          step_op;
        logic              sum_clear;
        logic              data_write;
        logic              out_load;
        out_sel_t          out_sel;
        logic [STAT_W-1:0] out_status;
        logic              drain_start;
        logic              drain_adv;
    } dp_cmd_t;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic              rx_sync;
        logic              sync_spent;
        logic              tick_timeout;
        logic              addr_echo_ok;
        logic              addr_last;
        logic              count_echo_ok;
        logic              data_more;
        logic              sum_ok;
        logic              count_zero;
        logic              out_free;
        logic              drain_last;
    } dp_stat_t;

endpackage

FILE: hdl/station_memory_read_handshake_top.sv
// Top level of the station memory read handshake: controller, datapath and checks.
// An accepted item is captured in the item register and then decided on, waiting for
// a free result register if the decision loads it; no new item is taken until it is done.
// A checksum match with a nonzero count sends its buffered bytes (at most 15), one per
// cycle while the result register is free, through the single registered read port.
// Reset is synchronous and active low; it returns to idle and resets the configuration.
`include "assert_macros.svh"

module station_memory_read_handshake_top import smrh_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    // Input items.
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // address[15:0], byte_count[19:16], rx_byte[27:20]
    input  logic [MODE_W-1:0]    s_tuser,   // mode[1:0]
    // Result items.
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // byte_value[7:0], status[10:8]
    output logic [KIND_W-1:0]    m_tuser,   // kind[1:0]
    output logic                 m_tlast,
    // Configuration writes.
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [WAIT_W-1:0]    cfg_data
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    // Configuration writes always taken; user (not block) makes them occur only while idle.
    assign cfg_ready = 1'b1;

    // The controller tracks the protocol phase and tells the datapath what to do
    // with each item once it has been captured in the item register.
    smrh_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // The datapath holds the address, count, checksum, timers, data buffer and the
    // result register that decouples the result side from the input side.
    smrh_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .stat      (stat),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    // A status-only item always closes a transaction and carries no byte.
    `SMRH_ASSERT_IMP(a_status_item_last, aclk, aresetn, m_tvalid && m_tuser == KIND_STATUS, m_tlast && m_tdata[7:0] == 8'd0)
    // A transmit byte never ends a transaction and never reports an error.
    `SMRH_ASSERT_IMP(a_tx_item_open, aclk, aresetn, m_tvalid && m_tuser == KIND_TX, !m_tlast && m_tdata[10:8] == STAT_OK)
    // No new item is taken while buffered data is being sent out.
    `SMRH_ASSERT_IMP(a_drain_blocks_input, aclk, aresetn, cmd.drain_adv, !s_tready)
    // Capturing an item and loading a result never happen in the same cycle.
    `SMRH_ASSERT_NEVER(a_load_exclusive, aclk, aresetn, cmd.in_load && cmd.out_load)

endmodule

FILE: hdl/smrh_dp.sv
// Datapath: item register, transaction counters, data buffer and result register.
module smrh_dp import smrh_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic [MODE_W-1:0]    s_tuser,
    input  logic                 cfg_valid,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [WAIT_W-1:0]    cfg_data,
    input  dp_cmd_t              cmd,
    output dp_stat_t             stat,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,
    output logic [KIND_W-1:0]    m_tuser,
    output logic                 m_tlast
);

    logic [MODE_W-1:0] in_mode_reg;
    logic [ADDR_W-1:0] in_addr_reg;
    logic [CNT_W-1:0]  in_count_reg;
    logic [BYTE_W-1:0] in_rx_reg;

    logic [ADDR_W-1:0] held_addr_reg;
    logic [CNT_W-1:0]  held_count_reg;
    logic [CNT_W-1:0]  step_reg;
    logic [BYTE_W-1:0] sum_reg;
    logic [WAIT_W-1:0] wait_reg;
    logic [WAIT_W-1:0] wait_next;
    logic [WAIT_W-1:0] wait_sat;
    logic [WAIT_W-1:0] retry_reg;
    logic [WAIT_W-1:0] timeout_reg;

    logic [BYTE_W-1:0] mem [MAX_READ_BYTES];
    logic [BYTE_W-1:0] rd_data_reg;
    logic [CNT_W-1:0]  rd_idx_reg;
    logic [CNT_W-1:0]  rd_plus;
    logic [CNT_W-1:0]  rd_addr;

    logic [CNT_W-1:0]  step_plus;
    logic [CNT_W-1:0]  latch_count;
    logic [3:0]        cur_nib;
    logic [3:0]        next_nib;

    logic              out_valid_reg;
    logic [KIND_W-1:0] out_kind_reg;
    logic [BYTE_W-1:0] out_byte_reg;
    logic [STAT_W-1:0] out_status_reg;
    logic              out_last_reg;

    function automatic logic [3:0] nib_sel(input logic [ADDR_W-1:0] a, input logic [1:0] i);
        logic [3:0] r;
        case (i)
            2'd0:    r = a[15:12];
            2'd1:    r = a[11:8];
            2'd2:    r = a[7:4];
            default: r = a[3:0];
        endcase
        return r;
    endfunction

    assign step_plus   = step_reg + 4'd1;
    assign rd_plus     = rd_idx_reg + 4'd1;
    assign cur_nib     = nib_sel(held_addr_reg, step_reg[1:0]);
    assign next_nib    = nib_sel(held_addr_reg, step_plus[1:0]);
    assign wait_sat    = (wait_reg < WAIT_MAX) ? wait_reg + 5'd1 : wait_reg;
    assign latch_count = (in_count_reg > CNT_W'(MAX_READ_BYTES)) ?
                         CNT_W'(MAX_READ_BYTES) : in_count_reg;

    always_comb begin
        case (cmd.wait_op)
            WAIT_CLEAR:   wait_next = '0;
            WAIT_ONE:     wait_next = 5'd1;
            WAIT_INC:     wait_next = wait_reg + 5'd1;
            WAIT_INC_SAT: wait_next = wait_sat;
            default:      wait_next = wait_reg;
        endcase
    end

    always_comb begin
        if (cmd.drain_start) begin
            rd_addr = '0;
        end else if (cmd.drain_adv) begin
            rd_addr = rd_plus;
        end else begin
            rd_addr = rd_idx_reg;
        end
    end

    always_comb begin
        stat.mode          = in_mode_reg;
        stat.rx_sync       = (in_rx_reg == RX_SYNC_ACK);
        stat.sync_spent    = (wait_reg >= retry_reg);
        stat.tick_timeout  = (wait_sat >= timeout_reg);
        stat.addr_echo_ok  = (in_rx_reg[7:4] == step_reg) && (in_rx_reg[3:0] == cur_nib);
        stat.addr_last     = (step_reg == CNT_W'(ADDR_NIBBLES - 1));
        stat.count_echo_ok = (in_rx_reg[3:0] == held_count_reg);
        stat.data_more     = (step_reg < held_count_reg);
        stat.sum_ok        = (in_rx_reg == sum_reg);
        stat.count_zero    = (held_count_reg == '0);
        stat.out_free      = !out_valid_reg || m_tready;
        stat.drain_last    = (rd_plus == held_count_reg);
    end

    // Item and transaction registers.
    always_ff @(posedge aclk) begin
        if (cmd.in_load) begin
            in_mode_reg  <= s_tuser;
            in_addr_reg  <= s_tdata[15:0];
            in_count_reg <= s_tdata[19:16];
            in_rx_reg    <= s_tdata[27:20];
        end
        if (!aresetn) begin
            held_addr_reg  <= '0;
            held_count_reg <= '0;
            step_reg       <= '0;
            sum_reg        <= '0;
            wait_reg       <= '0;
            rd_idx_reg     <= '0;
        end else begin
            if (cmd.start) begin
                held_addr_reg  <= in_addr_reg;
                held_count_reg <= latch_count;
            end
            case (cmd.step_op)
                STEP_CLEAR: step_reg <= '0;
                STEP_INC:   step_reg <= step_plus;
                default:    step_reg <= step_reg;
            endcase
            if (cmd.sum_clear) begin
                sum_reg <= '0;
            end else if (cmd.data_write) begin
                sum_reg <= sum_reg + in_rx_reg;
            end
            wait_reg   <= wait_next;
            rd_idx_reg <= rd_addr;
        end
    end

    // Configuration registers; the port never stalls.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            retry_reg   <= RETRY_RESET;
            timeout_reg <= TIMEOUT_RESET;
        end else if (cfg_valid) begin
            if (cfg_index == CFG_SYNC_RETRY) begin
                retry_reg <= cfg_data;
            end
            if (cfg_index == CFG_TIMEOUT) begin
                timeout_reg <= cfg_data;
            end
        end
    end

    // Data buffer with one write and one registered read port.
    always_ff @(posedge aclk) begin
        if (cmd.data_write) begin
            mem[step_reg] <= in_rx_reg;
        end
        if (rd_addr < CNT_W'(MAX_READ_BYTES)) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // Result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
        if (cmd.out_load) begin
            case (cmd.out_sel)
                OUT_NIB_FIRST: begin
                    out_kind_reg   <= KIND_TX;
                    out_byte_reg   <= TX_ADDR_BASE + {2'b00, nib_sel(held_addr_reg, 2'd0), 2'b00};
                    out_status_reg <= STAT_OK;
                    out_last_reg   <= 1'b0;
                end
                OUT_NIB_NEXT: begin
                    out_kind_reg   <= KIND_TX;
                    out_byte_reg   <= TX_ADDR_BASE + {2'b00, next_nib, 2'b00};
                    out_status_reg <= STAT_OK;
                    out_last_reg   <= 1'b0;
                end
                OUT_COUNT: begin
                    out_kind_reg   <= KIND_TX;
                    out_byte_reg   <= TX_COUNT_BASE + {2'b00, held_count_reg, 2'b00};
                    out_status_reg <= STAT_OK;
                    out_last_reg   <= 1'b0;
                end
                OUT_STATUS: begin
                    out_kind_reg   <= KIND_STATUS;
                    out_byte_reg   <= '0;
                    out_status_reg <= cmd.out_status;
                    out_last_reg   <= 1'b1;
                end
                OUT_DATA: begin
                    out_kind_reg   <= KIND_DATA;
                    out_byte_reg   <= rd_data_reg;
                    out_status_reg <= STAT_OK;
                    out_last_reg   <= stat.drain_last;
                end
                default: begin
                    out_kind_reg   <= KIND_TX;
                    out_byte_reg   <= TX_SYNC;
                    out_status_reg <= STAT_OK;
                    out_last_reg   <= 1'b0;
                end
            endcase
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'd0, out_status_reg, out_byte_reg};
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;

endmodule

FILE: hdl/smrh_ctrl.sv
// Controller: protocol phase and item sequencing for the read handshake.
module smrh_ctrl import smrh_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_tvalid,
    output logic     s_tready,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);

    typedef enum logic [2:0] {
        PH_IDLE, PH_SYNC, PH_FLUSH, PH_ADDR, PH_COUNT, PH_DATA
    } phase_t;

    typedef enum logic [1:0] {
        ENG_IDLE, ENG_EXEC, ENG_DRAIN
    } eng_t;

    phase_t  phase_reg, phase_next, phase_d;
    eng_t    eng_reg, eng_next, eng_d;
    dp_cmd_t act;
    logic    need_out;

    // Decision for the item held in the datapath.
    always_comb begin
        act      = '0;
        phase_d  = phase_reg;
        eng_d    = ENG_IDLE;
        need_out = 1'b0;
        if (stat.mode == MODE_START) begin
            act.start     = 1'b1;
            act.step_op   = STEP_CLEAR;
            act.sum_clear = 1'b1;
            act.wait_op   = WAIT_ONE;
            act.out_load  = 1'b1;
            act.out_sel   = OUT_SYNC;
            need_out      = 1'b1;
            phase_d       = PH_SYNC;
        end else if (stat.mode == MODE_TICK && phase_reg != PH_IDLE) begin
            case (phase_reg)
                PH_SYNC: begin
                    need_out     = 1'b1;
                    act.out_load = 1'b1;
                    if (stat.sync_spent) begin
                        act.out_sel    = OUT_STATUS;
                        act.out_status = STAT_SYNC_FAIL;
                        phase_d        = PH_IDLE;
                    end else begin
                        act.out_sel = OUT_SYNC;
                        act.wait_op = WAIT_INC;
                    end
                end
                PH_FLUSH: begin
                    act.step_op  = STEP_CLEAR;
                    act.wait_op  = WAIT_CLEAR;
                    act.out_load = 1'b1;
                    act.out_sel  = OUT_NIB_FIRST;
                    need_out     = 1'b1;
                    phase_d      = PH_ADDR;
                end
                default: begin
                    act.wait_op = WAIT_INC_SAT;
                    if (stat.tick_timeout) begin
                        act.out_load   = 1'b1;
                        act.out_sel    = OUT_STATUS;
                        act.out_status = STAT_TIMEOUT;
                        need_out       = 1'b1;
                        phase_d        = PH_IDLE;
                    end
                end
            endcase
        end else if (stat.mode == MODE_RX && phase_reg != PH_IDLE) begin
            case (phase_reg)
                PH_SYNC: begin
                    if (stat.rx_sync) begin
                        phase_d = PH_FLUSH;
                    end
                end
                PH_FLUSH: begin
                    phase_d = PH_FLUSH;
                end
                PH_ADDR: begin
                    need_out     = 1'b1;
                    act.out_load = 1'b1;
                    if (!stat.addr_echo_ok) begin
                        act.out_sel    = OUT_STATUS;
                        act.out_status = STAT_ECHO_ERR;
                        phase_d        = PH_IDLE;
                    end else begin
                        act.step_op = STEP_INC;
                        act.wait_op = WAIT_CLEAR;
                        if (stat.addr_last) begin
                            act.out_sel = OUT_COUNT;
                            phase_d     = PH_COUNT;
                        end else begin
                            act.out_sel = OUT_NIB_NEXT;
                        end
                    end
                end
                PH_COUNT: begin
                    if (!stat.count_echo_ok) begin
                        act.out_load   = 1'b1;
                        act.out_sel    = OUT_STATUS;
                        act.out_status = STAT_COUNT_ERR;
                        need_out       = 1'b1;
                        phase_d        = PH_IDLE;
                    end else begin
                        act.step_op   = STEP_CLEAR;
                        act.sum_clear = 1'b1;
                        act.wait_op   = WAIT_CLEAR;
                        phase_d       = PH_DATA;
                    end
                end
                PH_DATA: begin
                    act.wait_op = WAIT_CLEAR;
                    if (stat.data_more) begin
                        act.data_write = 1'b1;
                        act.step_op    = STEP_INC;
                    end else if (!stat.sum_ok) begin
                        act.out_load   = 1'b1;
                        act.out_sel    = OUT_STATUS;
                        act.out_status = STAT_CSUM_ERR;
                        need_out       = 1'b1;
                        phase_d        = PH_IDLE;
                    end else if (stat.count_zero) begin
                        act.out_load   = 1'b1;
                        act.out_sel    = OUT_STATUS;
                        act.out_status = STAT_OK;
                        need_out       = 1'b1;
                        phase_d        = PH_IDLE;
                    end else begin
                        act.drain_start = 1'b1;
                        eng_d           = ENG_DRAIN;
                        phase_d         = PH_IDLE;
                    end
                end
                default: begin
                    phase_d = PH_IDLE;
                end
            endcase
        end
    end

    // Engine sequencing; a decision that needs the result register waits for it.
    always_comb begin
        cmd        = '0;
        phase_next = phase_reg;
        eng_next   = eng_reg;
        s_tready   = 1'b0;
        case (eng_reg)
            ENG_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.in_load = 1'b1;
                    eng_next    = ENG_EXEC;
                end
            end
            ENG_EXEC: begin
                if (!need_out || stat.out_free) begin
                    cmd        = act;
                    phase_next = phase_d;
                    eng_next   = eng_d;
                end
            end
            ENG_DRAIN: begin
                if (stat.out_free) begin
                    cmd.out_load  = 1'b1;
                    cmd.out_sel   = OUT_DATA;
                    cmd.drain_adv = 1'b1;
                    if (stat.drain_last) begin
                        eng_next = ENG_IDLE;
                    end
                end
            end
            default: begin
                eng_next = ENG_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            eng_reg   <= ENG_IDLE;
        end else begin
            phase_reg <= phase_next;
            eng_reg   <= eng_next;
        end
    end

endmodule
